@@ sv/chrl_pkg.sv @@
package chrl_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int HASH_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int ENTRY_W  = HASH_W + HANDLE_W;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // read address source
  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_ZERO   = 2'd1,
    RD_PTR_DN = 2'd2,
    RD_PTR_UP = 2'd3
  } rd_sel_t;

  // write source: new entry at scan index, or moved entry at shift pointer
  typedef enum logic {
    WR_NEW  = 1'b0,
    WR_MOVE = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ptr_from_cnt;
    logic    ptr_from_idx;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    hit_set;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_t st_val;
    logic    found_load;
    logic    out_load;
  } chrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_end;
    logic stop;
    logic hit;
    logic full;
    logic empty;
    logic ptr_at_idx;
    logic ptr_last;
  } chrl_stat_t;

endpackage

@@ sv/chrl_datapath.sv @@
module chrl_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  chrl_pkg::chrl_cmd_t                cmd,
  output chrl_pkg::chrl_stat_t               stat,
  input  logic [chrl_pkg::OP_W-1:0]          opcode,
  input  logic [chrl_pkg::HASH_W-1:0]        key_hash,
  input  logic [chrl_pkg::HANDLE_W-1:0]      node_handle,
  output logic [chrl_pkg::ST_W-1:0]          status,
  output logic [chrl_pkg::HANDLE_W-1:0]      found_handle,
  output logic [chrl_pkg::CNT_W-1:0]         entry_count
);
  import chrl_pkg::*;

  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata;
  op_t                 op;
  logic [HASH_W-1:0]   key;
  logic [HANDLE_W-1:0] handle;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    cnt;
  logic                hit;
  status_t             st;
  logic [HANDLE_W-1:0] found;

  logic [CNT_W-1:0]    ptr_dn;
  logic [CNT_W-1:0]    ptr_up;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [HASH_W-1:0]   rd_pos;
  logic [HANDLE_W-1:0] rd_hdl;

  assign ptr_dn = ptr - 1'b1;
  assign ptr_up = ptr + 1'b1;
  assign rd_pos = rdata[ENTRY_W-1:HANDLE_W];
  assign rd_hdl = rdata[HANDLE_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx[ADDR_W-1:0];
      RD_ZERO:   rd_addr = '0;
      RD_PTR_DN: rd_addr = ptr_dn[ADDR_W-1:0];
      RD_PTR_UP: rd_addr = ptr_up[ADDR_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  assign wr_addr = (cmd.wr_sel == WR_NEW) ? idx[ADDR_W-1:0] : ptr[ADDR_W-1:0];
  assign wr_data = (cmd.wr_sel == WR_NEW) ? {key, handle} : rdata;

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_t'(opcode);
      key    <= key_hash;
      handle <= node_handle;
      idx    <= '0;
      hit    <= 1'b0;
      st     <= ST_OK;
      found  <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.hit_set) begin
        hit <= (rd_pos == key);
      end
      if (cmd.st_set) begin
        st <= cmd.st_val;
      end
      if (cmd.found_load) begin
        found <= rd_hdl;
      end
    end
    if (cmd.ptr_from_cnt) begin
      ptr <= cnt;
    end else if (cmd.ptr_from_idx) begin
      ptr <= idx;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_dn;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_up;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= st;
      found_handle <= found;
      entry_count  <= cnt;
    end
  end

  always_comb begin
    stat.op         = op;
    stat.scan_end   = (idx == cnt);
    // find wants the first hash above the key, insert/remove the first at or above
    stat.stop       = (op == OP_FIND) ? (rd_pos > key) : (rd_pos >= key);
    stat.hit        = hit;
    stat.full       = (cnt == CNT_W'(DEPTH));
    stat.empty      = (cnt == '0);
    stat.ptr_at_idx = (ptr == idx);
    stat.ptr_last   = (ptr_up == cnt);
  end

endmodule

@@ sv/chrl_ctrl.sv @@
module chrl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  chrl_pkg::chrl_stat_t stat,
  output chrl_pkg::chrl_cmd_t  cmd
);
  import chrl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_LOOKUP,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          state_next = S_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.stop) begin
          cmd.hit_set = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.hit) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_NEW;
              state_next = S_DONE;
            end else if (stat.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_FULL;
              state_next = S_DONE;
            end else begin
              cmd.ptr_from_cnt = 1'b1;
              state_next       = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            if (stat.hit) begin
              cmd.ptr_from_idx = 1'b1;
              state_next       = S_REM_RD;
            end else begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_NOT_FOUND;
              state_next = S_DONE;
            end
          end
          OP_FIND: begin
            if (stat.empty) begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = stat.scan_end ? RD_ZERO : RD_IDX;
              state_next = S_LOOKUP;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_LOOKUP: begin
        cmd.found_load = 1'b1;
        state_next     = S_DONE;
      end
      S_INS_RD: begin
        if (stat.ptr_at_idx) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_NEW;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_DN;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE;
        cmd.ptr_dec = 1'b1;
        state_next  = S_INS_RD;
      end
      S_REM_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_UP;
          state_next = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MOVE;
        cmd.ptr_inc = 1'b1;
        state_next  = S_REM_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/consistent_hash_ring_lookup.sv @@
// Consistent hashing ring lookup table.
// Request channel: in_valid/in_ready with opcode (insert, remove, find
// successor), key_hash and node_handle. Result channel: out_valid/out_ready
// with status, found_handle and entry_count; one result per request, in order.
// The table is a single-port-read, single-port-write memory of DEPTH entries
// kept sorted by hash. Each request walks it linearly from entry 0, reading each
// entry and then comparing the registered read data against the key.
// Inserting a new hash or removing a present one then shifts the tail by one
// entry at a time, a read then a write per move. The time from acceptance to
// out_valid grows with the number of entries read by the scan plus entries
// moved, longest for a lookup that runs past the last hash of a full ring.
// Requests are taken one at a time: in_ready is high only while no request
// is in progress, so a new request waits until the last has loaded its result.
// A finished result sits in an output register; the next request may be
// accepted while it waits. If out_ready stays low, the following request
// completes its work and then holds until the register is free.
// Reset (synchronous, active high) empties the ring at once; table contents
// are not cleared, since only entries below the count are ever read.
module consistent_hash_ring_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [chrl_pkg::OP_W-1:0]     opcode,
  input  logic [chrl_pkg::HASH_W-1:0]   key_hash,
  input  logic [chrl_pkg::HANDLE_W-1:0] node_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [chrl_pkg::ST_W-1:0]     status,
  output logic [chrl_pkg::HANDLE_W-1:0] found_handle,
  output logic [chrl_pkg::CNT_W-1:0]    entry_count
);
  import chrl_pkg::*;

  chrl_cmd_t  cmd;
  chrl_stat_t stat;

  chrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  chrl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .key_hash     (key_hash),
    .node_handle  (node_handle),
    .status       (status),
    .found_handle (found_handle),
    .entry_count  (entry_count)
  );

`ifndef NO_ASSERTIONS
  // count can never exceed table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CNT_W'(DEPTH)))
    else $error("entry_count above DEPTH");

  // a result with an error status carries no handle
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (found_handle == '0))
    else $error("found_handle nonzero on error status");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // an empty-ring status implies the ring really is empty
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EMPTY)) |-> (entry_count == '0))
    else $error("empty status with nonzero count");
`endif

endmodule
